@@ hdl/fdv_pkg.sv @@
// ----------------------------------------------------------------------------
// fdv_pkg
// Shared widths, types and helpers of the finite difference velocity block.
// ----------------------------------------------------------------------------
package fdv_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int TIME_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int FIELD_W = 32;  // width of the position and time beat fields
    localparam int TAG_W   = 32;
    localparam int OUT_W   = 48;

    // magnitude quotient: |dp| * 2^FRAC_BITS / |dt|, one bit per cycle
    localparam int QUO_W = POS_WIDTH + FRAC_BITS;
    localparam int SAT_W = ((QUO_W > OUT_W) ? QUO_W : OUT_W) + 1;
    localparam int CNT_W = $clog2(QUO_W);

    localparam logic [SAT_W-1:0] NEG_CAP = SAT_W'(1) << (OUT_W - 1);
    localparam logic [SAT_W-1:0] POS_CAP = NEG_CAP - SAT_W'(1);

    typedef logic [POS_WIDTH-1:0]  pos_t;
    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [POS_WIDTH:0]    pdiff_t;   // two's complement difference
    typedef logic [TIME_WIDTH:0]   tdiff_t;   // two's complement difference
    typedef logic [OUT_W-1:0]      vel_t;

    typedef struct packed {
        logic             mid_valid;
        logic             dt_zero;
        logic [TAG_W-1:0] tag;
    } win_stat_t;

    function automatic pos_t fit_pos(logic [FIELD_W-1:0] v);
        logic [2*FIELD_W+POS_WIDTH-1:0] w;
        w = {{(FIELD_W+POS_WIDTH){1'b0}}, v};
        return w[POS_WIDTH-1:0];
    endfunction

    function automatic time_t fit_time(logic [FIELD_W-1:0] v);
        logic [2*FIELD_W+TIME_WIDTH-1:0] w;
        w = {{(FIELD_W+TIME_WIDTH){1'b0}}, v};
        return w[TIME_WIDTH-1:0];
    endfunction

    function automatic logic [TAG_W-1:0] time_tag(time_t t);
        logic [TAG_W+TIME_WIDTH-1:0] w;
        w = {{TAG_W{1'b0}}, t};
        return w[TAG_W-1:0];
    endfunction

endpackage

@@ hdl/fdv_if.sv @@
// ----------------------------------------------------------------------------
// fdv_in_if / fdv_out_if
// Valid/ready channels for position beats and velocity beats.
// ----------------------------------------------------------------------------
interface fdv_in_if import fdv_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;
    logic [FIELD_W-1:0] epoch_time;

    modport source (output valid, pos_x, pos_y, pos_z, epoch_time, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, epoch_time, output ready);
endinterface

interface fdv_out_if import fdv_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] vel_x;
    logic [OUT_W-1:0] vel_y;
    logic [OUT_W-1:0] vel_z;
    logic [TAG_W-1:0] tag_time;
    logic             vel_valid;
    logic             div_error;

    modport source (output valid, vel_x, vel_y, vel_z, tag_time, vel_valid, div_error,
                    input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, tag_time, vel_valid, div_error,
                    output ready);
endinterface

@@ hdl/fdv_window.sv @@
// ----------------------------------------------------------------------------
// fdv_window
// Three-slot position/time window with difference selection.
// ----------------------------------------------------------------------------
module fdv_window import fdv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic [FIELD_W-1:0]   pos_x,
    input  logic [FIELD_W-1:0]   pos_y,
    input  logic [FIELD_W-1:0]   pos_z,
    input  logic [FIELD_W-1:0]   epoch_time,
    output pdiff_t [2:0]         num,
    output tdiff_t               den,
    output win_stat_t            stat
);

    pos_t  x_reg [3];
    pos_t  y_reg [3];
    pos_t  z_reg [3];
    time_t t_reg [3];

    logic [1:0] sel_a;
    logic [1:0] sel_b;
    time_t      ta;
    time_t      tb;

    // slot 0 oldest, slot 2 newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                x_reg[i] <= '0;
                y_reg[i] <= '0;
                z_reg[i] <= '0;
                t_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < 2; i++)
            begin
                x_reg[i] <= x_reg[i+1];
                y_reg[i] <= y_reg[i+1];
                z_reg[i] <= z_reg[i+1];
                t_reg[i] <= t_reg[i+1];
            end
            x_reg[2] <= fit_pos(pos_x);
            y_reg[2] <= fit_pos(pos_y);
            z_reg[2] <= fit_pos(pos_z);
            t_reg[2] <= fit_time(epoch_time);
        end
    end

    always_comb
    begin
        priority if (t_reg[0] == '0)
        begin
            sel_a = 2'd2;   // forward
            sel_b = 2'd1;
        end
        else if (t_reg[2] == '0)
        begin
            sel_a = 2'd1;   // backward
            sel_b = 2'd0;
        end
        else
        begin
            sel_a = 2'd2;   // central
            sel_b = 2'd0;
        end
    end

    assign ta = t_reg[sel_a];
    assign tb = t_reg[sel_b];

    assign num[0] = {x_reg[sel_a][POS_WIDTH-1], x_reg[sel_a]}
                  - {x_reg[sel_b][POS_WIDTH-1], x_reg[sel_b]};
    assign num[1] = {y_reg[sel_a][POS_WIDTH-1], y_reg[sel_a]}
                  - {y_reg[sel_b][POS_WIDTH-1], y_reg[sel_b]};
    assign num[2] = {z_reg[sel_a][POS_WIDTH-1], z_reg[sel_a]}
                  - {z_reg[sel_b][POS_WIDTH-1], z_reg[sel_b]};
    assign den    = {1'b0, ta} - {1'b0, tb};

    assign stat.mid_valid = (t_reg[1] != '0);
    assign stat.dt_zero   = (ta == tb);
    assign stat.tag       = time_tag(t_reg[1]);

endmodule

@@ hdl/fdv_div_lane.sv @@
// ----------------------------------------------------------------------------
// fdv_div_lane
// Bit-serial restoring divider: saturated (num * 2^FRAC_BITS) / den.
// ----------------------------------------------------------------------------
module fdv_div_lane import fdv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  pdiff_t num,
    input  tdiff_t den,
    output logic   busy,
    output vel_t   vel
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ABS  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_SAT  = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    pdiff_t                num_reg;
    tdiff_t                den_reg;
    logic [QUO_W-1:0]      nsh_reg, nsh_next;    // numerator bits, MSB first
    time_t                 dmag_reg, dmag_next;
    time_t                 rem_reg, rem_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    vel_t                  vel_reg, vel_next;

    pdiff_t                nmag;
    tdiff_t                dmag_full;
    logic [TIME_WIDTH:0]   trial;
    logic [TIME_WIDTH:0]   trial_sub;
    logic                  ge;
    logic [SAT_W-1:0]      q_ext;
    logic [SAT_W-1:0]      mag;
    logic [SAT_W-1:0]      neg_mag;

    assign nmag      = num_reg[POS_WIDTH]  ? (~num_reg + 1'b1) : num_reg;
    assign dmag_full = den_reg[TIME_WIDTH] ? (~den_reg + 1'b1) : den_reg;

    assign trial     = {rem_reg, nsh_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, dmag_reg};
    assign ge        = (trial >= {1'b0, dmag_reg});

    assign q_ext   = SAT_W'(quo_reg);
    assign mag     = neg_reg ? ((q_ext > NEG_CAP) ? NEG_CAP : q_ext)
                             : ((q_ext > POS_CAP) ? POS_CAP : q_ext);
    assign neg_mag = SAT_W'(0) - mag;

    always_comb
    begin
        phase_next = phase_reg;
        nsh_next   = nsh_reg;
        dmag_next  = dmag_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        vel_next   = vel_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                    phase_next = PH_ABS;
            end
            PH_ABS:
            begin
                nsh_next   = QUO_W'(nmag) << FRAC_BITS;
                dmag_next  = dmag_full[TIME_WIDTH-1:0];
                neg_next   = num_reg[POS_WIDTH] ^ den_reg[TIME_WIDTH];
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                phase_next = PH_DIV;
            end
            PH_DIV:
            begin
                // remainder stays below the divisor, so it fits TIME_WIDTH bits
                rem_next = ge ? trial_sub[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
                quo_next = {quo_reg[QUO_W-2:0], ge};
                nsh_next = nsh_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                    phase_next = PH_SAT;
            end
            PH_SAT:
            begin
                vel_next   = neg_reg ? neg_mag[OUT_W-1:0] : mag[OUT_W-1:0];
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (start && phase_reg == PH_IDLE)
        begin
            num_reg <= num;
            den_reg <= den;
        end
        nsh_reg  <= nsh_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        vel_reg  <= vel_next;
    end

    assign busy = (phase_reg != PH_IDLE);
    assign vel  = vel_reg;

endmodule

@@ hdl/finite_difference_velocity_top.sv @@
// ----------------------------------------------------------------------------
// finite_difference_velocity_top
// Finite-difference velocity from a three-deep window of timestamped positions.
// ----------------------------------------------------------------------------
//
//  channel   dir   beat payload                                   handshake
//  in_ch     in    pos_x, pos_y, pos_z, epoch_time                valid/ready
//  out_ch    out   vel_x, vel_y, vel_z, tag_time, vel_valid,      valid/ready
//                  div_error
//
//  A beat that leads to a division holds off the next accept until the
//  division is done and its result is loaded: three bit-serial
//  restoring dividers, one per axis, each produce one quotient bit per cycle.
//  A beat with an empty middle slot or equal times skips the dividers.
//  Reset empties the window (all times zero) and drops any pending result.
//  The result waits in the output register; in_ch may accept the next beat
//  while it waits, and only the hand-over of a new result stalls on out_ch.
//
module finite_difference_velocity_top import fdv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    fdv_in_if.sink   in_ch,
    fdv_out_if.source out_ch
);

    // control states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // result kind
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_ERR   = 2'd1;
    localparam logic [1:0] KIND_DIV   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       kind_reg, kind_next;
    logic             out_valid_reg, out_valid_next;
    vel_t             vx_reg, vy_reg, vz_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             vvalid_reg;
    logic             derr_reg;

    logic             accept;
    logic             lane_start;
    logic             load_out;
    logic [2:0]       lane_busy;
    vel_t [2:0]       lane_vel;
    pdiff_t [2:0]     num;
    tdiff_t           den;
    win_stat_t        stat;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // window shifts on every accepted beat
    fdv_window u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (accept),
        .pos_x      (in_ch.pos_x),
        .pos_y      (in_ch.pos_y),
        .pos_z      (in_ch.pos_z),
        .epoch_time (in_ch.epoch_time),
        .num        (num),
        .den        (den),
        .stat       (stat)
    );

    // one divider per axis, all started together, all finish together
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        fdv_div_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start),
            .num   (num[g]),
            .den   (den),
            .busy  (lane_busy[g]),
            .vel   (lane_vel[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        lane_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                // window now holds the new beat; classify it
                priority if (!stat.mid_valid)
                begin
                    kind_next  = KIND_EMPTY;
                    state_next = ST_FINISH;
                end
                else if (stat.dt_zero)
                begin
                    kind_next  = KIND_ERR;
                    state_next = ST_FINISH;
                end
                else
                begin
                    kind_next  = KIND_DIV;
                    lane_start = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!(|lane_busy))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            unique case (kind_reg)
                KIND_DIV:
                begin
                    vx_reg     <= lane_vel[0];
                    vy_reg     <= lane_vel[1];
                    vz_reg     <= lane_vel[2];
                    tag_reg    <= stat.tag;
                    vvalid_reg <= 1'b1;
                    derr_reg   <= 1'b0;
                end
                KIND_ERR:
                begin
                    vx_reg     <= '0;
                    vy_reg     <= '0;
                    vz_reg     <= '0;
                    tag_reg    <= stat.tag;
                    vvalid_reg <= 1'b1;
                    derr_reg   <= 1'b1;
                end
                default:
                begin
                    vx_reg     <= '0;
                    vy_reg     <= '0;
                    vz_reg     <= '0;
                    tag_reg    <= '0;
                    vvalid_reg <= 1'b0;
                    derr_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.vel_x     = vx_reg;
    assign out_ch.vel_y     = vy_reg;
    assign out_ch.vel_z     = vz_reg;
    assign out_ch.tag_time  = tag_reg;
    assign out_ch.vel_valid = vvalid_reg;
    assign out_ch.div_error = derr_reg;

    // dividers are quiet whenever a new beat may be taken
    a_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !(|lane_busy))
        else $error("divider busy while idle");

    // an accepted beat is classified in the next cycle
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SETUP)
        else $error("accepted beat not classified");

    // a zero time difference gives zero velocity on a valid result
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.div_error |->
            out_ch.vel_valid && out_ch.vel_x == '0 && out_ch.vel_y == '0
            && out_ch.vel_z == '0)
        else $error("div_error with nonzero velocity");

    // an empty middle slot gives an all-zero result
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.vel_valid |->
            !out_ch.div_error && out_ch.tag_time == '0 && out_ch.vel_x == '0
            && out_ch.vel_y == '0 && out_ch.vel_z == '0)
        else $error("empty-window result not cleared");

endmodule

@@ tb/finite_difference_velocity_top_test.sv @@
// ----------------------------------------------------------------------------
// finite_difference_velocity_top_test
// Self-checking bench for the finite difference velocity block: directed
// window, equal-time and extreme-value cases, then random position tracks
// with noise, all checked beat by beat against an in-bench window predictor.
// ----------------------------------------------------------------------------
module finite_difference_velocity_top_test import fdv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD  = 20;
    localparam int  RESET_CYCLES = 8;
    localparam int  DRAIN_CYCLES = 64;       // a bit more than one divide pass
    localparam int  CYCLE_LIMIT  = 600_000;  // stops a hung run
    localparam int  RANDOM_BEATS = 400;      // per idle phase
    localparam int  REPORT_MAX   = 10;

    // One velocity beat as seen on out_ch.
    typedef struct {
        vel_t             vx;
        vel_t             vy;
        vel_t             vz;
        logic [TAG_W-1:0] tag;
        logic             mid_ok;
        logic             dt_err;
    } velocity_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    fdv_in_if  in_ch ();
    fdv_out_if out_ch ();

    finite_difference_velocity_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: the three-deep window, slot 0 oldest, slot 2 newest.
    // Reset leaves every slot empty (time zero).
    pos_t  win_x [3] = '{default: '0};
    pos_t  win_y [3] = '{default: '0};
    pos_t  win_z [3] = '{default: '0};
    time_t win_t [3] = '{default: '0};

    velocity_beat_t pending_velocities [$];

    int in_idle_pct;
    int out_idle_pct;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // (num * 2^FRAC_BITS) / den, truncated toward zero, saturated to OUT_W
    // bits signed. The fraction loop stops early once the magnitude is past
    // the negative cap; saturation takes care of the rest.
    function automatic vel_t scaled_quotient(longint num, longint den);
        logic              neg;
        longint unsigned   n;
        longint unsigned   d;
        longint unsigned   q;
        longint unsigned   r;
        longint unsigned   cap;
        int                i;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        q   = n / d;
        r   = n % d;
        cap = 64'd1 << (OUT_W - 1);
        for (i = 0; i < FRAC_BITS && q <= cap; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        if (neg)
        begin
            if (q > cap)
                q = cap;
            return vel_t'(-q);
        end
        if (q > cap - 1)
            q = cap - 1;
        return vel_t'(q);
    endfunction

    // Shift one position beat into the window and work out its velocity beat.
    function automatic velocity_beat_t advance_window(logic [FIELD_W-1:0] px,
                                                      logic [FIELD_W-1:0] py,
                                                      logic [FIELD_W-1:0] pz,
                                                      logic [FIELD_W-1:0] t);
        velocity_beat_t v;
        int             a;
        int             b;
        longint         dt;
        for (int i = 0; i < 2; i++)
        begin
            win_x[i] = win_x[i + 1];
            win_y[i] = win_y[i + 1];
            win_z[i] = win_z[i + 1];
            win_t[i] = win_t[i + 1];
        end
        win_x[2] = pos_t'(px);
        win_y[2] = pos_t'(py);
        win_z[2] = pos_t'(pz);
        win_t[2] = time_t'(t);

        v = '{default: '0};
        if (win_t[1] == '0)
            return v;               // empty middle slot: all fields zero
        v.tag    = win_t[1];
        v.mid_ok = 1'b1;

        if (win_t[0] == '0)
        begin
            a = 2;                  // forward: newest against middle
            b = 1;
        end
        else if (win_t[2] == '0)
        begin
            a = 1;                  // backward: middle against oldest
            b = 0;
        end
        else
        begin
            a = 2;                  // central: newest against oldest
            b = 0;
        end

        dt = longint'(win_t[a]) - longint'(win_t[b]);
        if (dt == 0)
        begin
            v.dt_err = 1'b1;        // equal times: velocity stays zero
            return v;
        end
        v.vx = scaled_quotient(longint'($signed(win_x[a])) - longint'($signed(win_x[b])), dt);
        v.vy = scaled_quotient(longint'($signed(win_y[a])) - longint'($signed(win_y[b])), dt);
        v.vz = scaled_quotient(longint'($signed(win_z[a])) - longint'($signed(win_z[b])), dt);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Driving. Inputs move on the falling edge, handshakes are seen on the
    // rising edge. valid is only dropped when an idle cycle is picked, so a
    // back-to-back beat never sees valid lowered and raised in one step.
    // ------------------------------------------------------------------------

    task automatic send_beat(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
                             logic [FIELD_W-1:0] pz, logic [FIELD_W-1:0] t);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.pos_x      <= px;
        in_ch.pos_y      <= py;
        in_ch.pos_z      <= pz;
        in_ch.epoch_time <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // beat accepted at this edge
        pending_velocities.push_back(advance_window(px, py, pz, t));
    endtask

    // Receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);

    // ------------------------------------------------------------------------
    // Checking: every velocity beat against the oldest pending prediction.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        velocity_beat_t want;
        velocity_beat_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.vx     = out_ch.vel_x;
            got.vy     = out_ch.vel_y;
            got.vz     = out_ch.vel_z;
            got.tag    = out_ch.tag_time;
            got.mid_ok = out_ch.vel_valid;
            got.dt_err = out_ch.div_error;
            if (pending_velocities.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("[%0t] unexpected velocity beat: vx=%h vy=%h vz=%h tag=%h v=%b e=%b",
                             $realtime, got.vx, got.vy, got.vz, got.tag,
                             got.mid_ok, got.dt_err);
            end
            else
            begin
                want = pending_velocities.pop_front();
                if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                    got.tag !== want.tag || got.mid_ok !== want.mid_ok ||
                    got.dt_err !== want.dt_err)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("[%0t] velocity mismatch", $realtime);
                        $display("    expected vx=%h vy=%h vz=%h tag=%h v=%b e=%b",
                                 want.vx, want.vy, want.vz, want.tag,
                                 want.mid_ok, want.dt_err);
                        $display("    actual   vx=%h vy=%h vz=%h tag=%h v=%b e=%b",
                                 got.vx, got.vy, got.vz, got.tag,
                                 got.mid_ok, got.dt_err);
                    end
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fill the window from empty and walk through every slot pattern:
    // empty middle, forward, central, backward.
    task automatic test_window_modes();
        send_beat(32'd100,  32'd200,          32'd300,       32'd100);  // middle empty
        send_beat(32'd1100, -32'sd400,        32'd0,         32'd200);  // forward
        send_beat(32'd2100, -32'sd900,        32'd7,         32'd300);  // central
        send_beat(32'd5,    32'd5,            32'd5,         32'd0);    // backward
        send_beat(32'd9,    32'd9,            32'd9,         32'd400);  // middle empty
        send_beat(32'd77,   32'hFFFF_FF00,    32'd1234,      32'd500);  // forward
    endtask

    // Equal times on each difference form raise the error flag.
    task automatic test_div_error();
        send_beat(32'd1,    32'd2,   32'd3,   32'd0);
        send_beat(32'd10,   32'd20,  32'd30,  32'd900);
        send_beat(32'd40,   32'd50,  32'd60,  32'd900);   // forward, equal times
        send_beat(32'd0,    32'd0,   32'd0,   32'd0);     // backward, equal times
        send_beat(32'd3,    32'd3,   32'd3,   32'd700);   // middle empty
        send_beat(32'd13,   32'd23,  32'd33,  32'd800);   // forward
        send_beat(32'd99,   32'd98,  32'd97,  32'd700);   // central, equal times
    endtask

    // Falling time, saturation both ways, largest time, truncation toward zero.
    task automatic test_extremes();
        send_beat(32'd100,        32'd100,        32'd100,        32'd5000);
        send_beat(32'd200,        32'd50,         32'd300,        32'd4000);  // falling time
        send_beat(32'd300,        32'd0,          32'd500,        32'd3000);
        send_beat(32'd0,          32'd0,          32'd0,          32'd0);
        send_beat(32'h7FFF_FFFF,  32'h8000_0000,  32'd0,          32'd10);
        send_beat(32'h8000_0000,  32'h7FFF_FFFF,  32'hFFFF_FFFF,  32'd11);    // saturates
        send_beat(32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0000,  32'hFFFF_FFFF);
        send_beat(32'd0,          32'd0,          32'd0,          32'd0);
        send_beat(32'd0,          32'd0,          32'd0,          32'd1);
        send_beat(32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFE,  32'd4);     // dt = 3
    endtask

    // Mostly well-formed tracks with rising time and random motion, mixed
    // with empty slots, repeated and falling times, and raw noise beats.
    task automatic test_random_traffic(int beats);
        logic [FIELD_W-1:0] trk_x;
        logic [FIELD_W-1:0] trk_y;
        logic [FIELD_W-1:0] trk_z;
        logic [FIELD_W-1:0] trk_t;
        logic [FIELD_W-1:0] last_t;
        int                 pick;
        trk_x  = $urandom;
        trk_y  = $urandom;
        trk_z  = $urandom;
        trk_t  = $urandom;
        last_t = trk_t;
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                // new track somewhere else in space and time
                trk_x = $urandom;
                trk_y = $urandom;
                trk_z = $urandom;
                trk_t = $urandom;
                send_beat(trk_x, trk_y, trk_z, trk_t);
            end
            else if (pick < 12)
                send_beat($urandom, $urandom, $urandom, 32'd0);          // empty slot
            else if (pick < 16)
                send_beat($urandom, $urandom, $urandom, last_t);         // repeated time
            else if (pick < 20)
                send_beat($urandom, $urandom, $urandom,
                          trk_t - $urandom_range(1, 3000));              // falling time
            else if (pick < 24)
                send_beat($urandom, $urandom, $urandom, $urandom);       // noise
            else
            begin
                trk_x += $signed($urandom) >>> $urandom_range(31);
                trk_y += $signed($urandom) >>> $urandom_range(31);
                trk_z += $signed($urandom) >>> $urandom_range(31);
                trk_t += ($urandom_range(9) == 0) ? $urandom_range(1, 1 << 20)
                                                  : $urandom_range(1, 200);
                send_beat(trk_x, trk_y, trk_z, trk_t);
            end
            last_t = in_ch.epoch_time;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.pos_x      = '0;
        in_ch.pos_y      = '0;
        in_ch.pos_z      = '0;
        in_ch.epoch_time = '0;
        in_idle_pct      = 12;
        out_idle_pct     = 64;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_window_modes();
        test_div_error();
        test_extremes();
        test_random_traffic(RANDOM_BEATS);

        in_idle_pct  = 64;
        out_idle_pct = 12;
        test_random_traffic(RANDOM_BEATS);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_traffic(RANDOM_BEATS);

        @(negedge clk);
        in_ch.valid <= 1'b0;

        // drain, then give the block time to show any stray beat
        while (pending_velocities.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_velocities.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
